// ===== design/epoch_seconds_to_calendar_core_defines.svh =====
// Assertion macros shared by the epoch to calendar converter.
// Depends on nothing; the asserting module must have clk and rst_n in scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPCAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EPCAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/epcal_pkg.sv =====
// Shared types and constants for the epoch to calendar converter.
// No dependencies; used by epcal_ctrl, epcal_dp and the top level.
package epcal_pkg;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [11:0] CENTURY_YEAR  = 12'd2100;

    // Reciprocal division by a constant: q = (x * RECIP) >> SHIFT, exact over
    // each dividend range. Seconds are divided by 128 first, leaving 675.
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam int          DAY_SHIFT  = 35;
    localparam logic [25:0] HOUR_RECIP = 26'd149131;
    localparam int          HOUR_SHIFT = 29;
    localparam logic [25:0] MIN_RECIP  = 26'd4370;
    localparam int          MIN_SHIFT  = 18;
    localparam logic [25:0] YEAR_RECIP = 26'd91930;
    localparam int          YEAR_SHIFT = 25;

    // Year offset from which the century (non-leap 2100) has been passed
    localparam logic [7:0] CENTURY_Q = 8'(CENTURY_YEAR - EPOCH_YEAR + 12'd1);

    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_DEC = 4'd11;

    localparam logic [4:0] MONTH_DAYS [12] =
        '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
          5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

    typedef enum logic [1:0] {
        SEL_DAY,
        SEL_HOUR,
        SEL_MIN,
        SEL_YEAR
    } div_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_DAY,
        OP_QUO,
        OP_REM,
        OP_LOAD_HOUR,
        OP_LOAD_MIN,
        OP_LOAD_YEAR,
        OP_FIX_YEAR,
        OP_MONTH,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic month_done;
    } sts_t;

    // Gregorian leap rule, valid over 1969..2106
    function automatic logic is_leap(input logic [11:0] y);
        return (y[1:0] == 2'b00) && (y != CENTURY_YEAR);
    endfunction

endpackage

// ===== design/epoch_seconds_to_calendar_core.sv =====
// Epoch seconds to Gregorian calendar date and time of day.
// Input channel epoch_valid/epoch_stall carries one request: a 32-bit
// unsigned count of seconds since 1970-01-01 00:00:00.
// Output channel cal_valid/cal_stall returns year, month, day_of_month,
// hour, minute and second for each request, in order, one per request.
// A request is taken when the block is idle; it then runs through one
// shared reciprocal-multiply divider (a quotient step then a remainder
// step per division, for days, hours, minutes and the year estimate, with
// a load step before each of the last three), a year correction step, a
// month walk from January and a publish step. The next request is taken
// only after the previous one has been published.
// The result sits in an output register: a stalled result holds while the
// next request is accepted and computed; a finished request waits in the
// done state until the output register is free.
// Reset (rst_n low, asynchronous) returns to idle and drops cal_valid.
// Depends on epcal_pkg, epcal_ctrl and epcal_dp.
module epoch_seconds_to_calendar_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        epoch_valid,
    output logic        epoch_stall,
    input  logic [31:0] epoch_seconds,
    output logic        cal_valid,
    input  logic        cal_stall,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);
    import epcal_pkg::*;

    cmd_t cmd;
    sts_t sts;

    epcal_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .epoch_valid (epoch_valid),
        .epoch_stall (epoch_stall),
        .cal_valid   (cal_valid),
        .cal_stall   (cal_stall),
        .cmd         (cmd),
        .sts         (sts)
    );

    epcal_dp u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .sts           (sts),
        .epoch_seconds (epoch_seconds),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second)
    );

endmodule

// ===== design/epcal_dp.sv =====
// Datapath: shared reciprocal divider, year correction, month walk,
// and the result register. Depends on epcal_pkg; driven by epcal_ctrl.
module epcal_dp (
    input  logic               clk,
    input  epcal_pkg::cmd_t    cmd,
    output epcal_pkg::sts_t    sts,
    input  logic [31:0]        epoch_seconds,
    output logic [11:0]        year,
    output logic [3:0]         month,
    output logic [4:0]         day_of_month,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second
);
    import epcal_pkg::*;

    logic [31:0] rem_reg, rem_next;
    div_sel_t    sel_reg, sel_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] days_reg, days_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [5:0]  sec_reg, sec_next;
    logic [11:0] year_reg, year_next;
    logic [8:0]  doy_reg, doy_next;
    logic [3:0]  mon_reg, mon_next;
    logic        leap_reg, leap_next;

    logic [11:0] out_year_reg, out_year_next;
    logic [3:0]  out_mon_reg, out_mon_next;
    logic [4:0]  out_day_reg, out_day_next;
    logic [4:0]  out_hour_reg, out_hour_next;
    logic [5:0]  out_min_reg, out_min_next;
    logic [5:0]  out_sec_reg, out_sec_next;

    logic [24:0]       mul_a;
    logic [25:0]       mul_b;
    logic [50:0]       prod;
    logic [16:0]       divisor;
    logic [31:0]       rem_prod;
    logic [15:0]       quo_new;
    logic [5:0]        leaps;
    logic signed [9:0] doy_est;
    logic [11:0]       year_est;
    logic [11:0]       year_dec;
    logic              leap_dec;
    logic [4:0]        mon_len;
    logic              month_done;

    always_comb
    begin
        case (sel_reg)
            SEL_DAY:
            begin
                // 86400 = 128 * 675: drop the low 7 bits first
                mul_a   = rem_reg[31:7];
                mul_b   = DAY_RECIP;
                divisor = SECS_PER_DAY;
            end
            SEL_HOUR:
            begin
                mul_a   = rem_reg[24:0];
                mul_b   = HOUR_RECIP;
                divisor = SECS_PER_HOUR;
            end
            SEL_MIN:
            begin
                mul_a   = rem_reg[24:0];
                mul_b   = MIN_RECIP;
                divisor = SECS_PER_MIN;
            end
            default:
            begin
                mul_a   = rem_reg[24:0];
                mul_b   = YEAR_RECIP;
                divisor = DAYS_PER_YEAR;
            end
        endcase
    end

    assign prod     = {26'b0, mul_a} * {25'b0, mul_b};
    assign rem_prod = {16'b0, quo_reg} * {15'b0, divisor};

    always_comb
    begin
        case (sel_reg)
            SEL_DAY:  quo_new = 16'(prod >> DAY_SHIFT);
            SEL_HOUR: quo_new = 16'(prod >> HOUR_SHIFT);
            SEL_MIN:  quo_new = 16'(prod >> MIN_SHIFT);
            default:  quo_new = 16'(prod >> YEAR_SHIFT);
        endcase
    end

    // Leap days in [1970, year_est - 1]: every fourth year from 1972, less 2100
    assign year_est = EPOCH_YEAR + 12'(quo_reg[7:0]);
    assign year_dec = year_est - 12'd1;
    assign leap_dec = is_leap(year_dec);
    assign leaps    = 6'(({1'b0, quo_reg[7:0]} + 9'd1) >> 2)
                    - 6'(quo_reg[7:0] >= CENTURY_Q);
    assign doy_est  = $signed({1'b0, rem_reg[8:0]}) - $signed({4'b0, leaps});

    assign mon_len    = MONTH_DAYS[mon_reg] + 5'((mon_reg == MON_FEB) && leap_reg);
    assign month_done = (mon_reg == MON_DEC) || (doy_reg < 9'(mon_len));
    assign sts.month_done = month_done;

    always_comb
    begin
        rem_next      = rem_reg;
        sel_next      = sel_reg;
        quo_next      = quo_reg;
        days_next     = days_reg;
        hour_next     = hour_reg;
        min_next      = min_reg;
        sec_next      = sec_reg;
        year_next     = year_reg;
        doy_next      = doy_reg;
        mon_next      = mon_reg;
        leap_next     = leap_reg;
        out_year_next = out_year_reg;
        out_mon_next  = out_mon_reg;
        out_day_next  = out_day_reg;
        out_hour_next = out_hour_reg;
        out_min_next  = out_min_reg;
        out_sec_next  = out_sec_reg;
        case (cmd.op)
            OP_LOAD_DAY:
            begin
                rem_next = epoch_seconds;
                sel_next = SEL_DAY;
            end
            OP_QUO:
            begin
                quo_next = quo_new;
            end
            OP_REM:
            begin
                rem_next = rem_reg - rem_prod;
            end
            OP_LOAD_HOUR:
            begin
                days_next = quo_reg;
                sel_next  = SEL_HOUR;
            end
            OP_LOAD_MIN:
            begin
                hour_next = quo_reg[4:0];
                sel_next  = SEL_MIN;
            end
            OP_LOAD_YEAR:
            begin
                min_next = quo_reg[5:0];
                sec_next = rem_reg[5:0];
                rem_next = {16'b0, days_reg};
                sel_next = SEL_YEAR;
            end
            OP_FIX_YEAR:
            begin
                mon_next = MON_JAN;
                // Estimate overshoots by at most one year: step back once
                if (doy_est < 0)
                begin
                    year_next = year_dec;
                    leap_next = leap_dec;
                    doy_next  = 9'(doy_est + 10'sd365 + $signed({9'b0, leap_dec}));
                end
                else
                begin
                    year_next = year_est;
                    leap_next = is_leap(year_est);
                    doy_next  = 9'(doy_est);
                end
            end
            OP_MONTH:
            begin
                if (!month_done)
                begin
                    doy_next = doy_reg - 9'(mon_len);
                    mon_next = mon_reg + 4'd1;
                end
            end
            OP_PUBLISH:
            begin
                out_year_next = year_reg;
                out_mon_next  = mon_reg + 4'd1;
                out_day_next  = doy_reg[4:0] + 5'd1;
                out_hour_next = hour_reg;
                out_min_next  = min_reg;
                out_sec_next  = sec_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        sel_reg      <= sel_next;
        quo_reg      <= quo_next;
        days_reg     <= days_next;
        hour_reg     <= hour_next;
        min_reg      <= min_next;
        sec_reg      <= sec_next;
        year_reg     <= year_next;
        doy_reg      <= doy_next;
        mon_reg      <= mon_next;
        leap_reg     <= leap_next;
        out_year_reg <= out_year_next;
        out_mon_reg  <= out_mon_next;
        out_day_reg  <= out_day_next;
        out_hour_reg <= out_hour_next;
        out_min_reg  <= out_min_next;
        out_sec_reg  <= out_sec_next;
    end

    assign year         = out_year_reg;
    assign month        = out_mon_reg;
    assign day_of_month = out_day_reg;
    assign hour         = out_hour_reg;
    assign minute       = out_min_reg;
    assign second       = out_sec_reg;

endmodule

// ===== design/epcal_ctrl.sv =====
// Controller: sequences the datapath through the divisions, the year
// correction and the month walk. Depends on epcal_pkg and the defines header.
`include "epoch_seconds_to_calendar_core_defines.svh"

module epcal_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            epoch_valid,
    output logic            epoch_stall,
    output logic            cal_valid,
    input  logic            cal_stall,
    output epcal_pkg::cmd_t cmd,
    input  epcal_pkg::sts_t sts
);
    import epcal_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_DAY,
        S_LD_HOUR,
        S_DIV_HOUR,
        S_LD_MIN,
        S_DIV_MIN,
        S_LD_YEAR,
        S_DIV_YEAR,
        S_FIX,
        S_MONTH,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    // High for the quotient step of a division, low for the remainder step
    logic       cnt_reg, cnt_next;
    logic       valid_reg, valid_next;
    logic       accept;
    logic       publish;

    assign accept  = (state_reg == S_IDLE) && epoch_valid;
    assign publish = (state_reg == S_DONE) && (!valid_reg || !cal_stall);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (epoch_valid)
                begin
                    cmd.op     = OP_LOAD_DAY;
                    cnt_next   = 1'b1;
                    state_next = S_DIV_DAY;
                end
            end
            S_DIV_DAY, S_DIV_HOUR, S_DIV_MIN, S_DIV_YEAR:
            begin
                if (cnt_reg)
                begin
                    cmd.op   = OP_QUO;
                    cnt_next = 1'b0;
                end
                else
                begin
                    cmd.op = OP_REM;
                    case (state_reg)
                        S_DIV_DAY:  state_next = S_LD_HOUR;
                        S_DIV_HOUR: state_next = S_LD_MIN;
                        S_DIV_MIN:  state_next = S_LD_YEAR;
                        default:    state_next = S_FIX;
                    endcase
                end
            end
            S_LD_HOUR:
            begin
                cmd.op     = OP_LOAD_HOUR;
                cnt_next   = 1'b1;
                state_next = S_DIV_HOUR;
            end
            S_LD_MIN:
            begin
                cmd.op     = OP_LOAD_MIN;
                cnt_next   = 1'b1;
                state_next = S_DIV_MIN;
            end
            S_LD_YEAR:
            begin
                cmd.op     = OP_LOAD_YEAR;
                cnt_next   = 1'b1;
                state_next = S_DIV_YEAR;
            end
            S_FIX:
            begin
                cmd.op     = OP_FIX_YEAR;
                state_next = S_MONTH;
            end
            S_MONTH:
            begin
                cmd.op = OP_MONTH;
                if (sts.month_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the result register is free
                if (publish)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (publish)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !cal_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    assign epoch_stall = (state_reg != S_IDLE);
    assign cal_valid   = valid_reg;

    `EPCAL_ASSERT_NEXT(a_accept_starts_day, accept,
        (state_reg == S_DIV_DAY) && cnt_reg,
        "accepted request did not start the day division")
    `EPCAL_ASSERT_NEXT(a_publish_valid, publish,
        valid_reg && (state_reg == S_IDLE),
        "published result not presented")
    `EPCAL_ASSERT_NOW(a_no_overwrite, valid_reg && cal_stall,
        !publish,
        "result overwritten while stalled")
    `EPCAL_ASSERT_NEXT(a_month_exit, (state_reg == S_MONTH) && sts.month_done,
        state_reg == S_DONE,
        "month walk did not finish")

endmodule

// ===== verif/tb_epoch_seconds_to_calendar_core.sv =====
// Testbench for epoch_seconds_to_calendar_core: sends epoch second counts,
// predicts the Gregorian date and time of day of each and checks every result.
// Depends only on the RTL of epoch_seconds_to_calendar_core.
module tb_epoch_seconds_to_calendar_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 3;
    localparam int RUN_LIMIT      = 300000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_REQS    = 400;
    localparam int IDLE_PCT       = 8;
    localparam int CALM_FROM      = 2000;
    localparam int CALM_TO        = 4500;
    localparam int HOLDOFF_AFTER  = 60;
    localparam int HOLDOFF_CYCLES = 400;

    localparam int unsigned DAY_SECS  = 86400;
    localparam int unsigned HOUR_SECS = 3600;
    localparam int          BASE_YEAR = 1970;
    localparam longint      MAX_SECS  = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  mday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } calendar_t;

    typedef struct packed {
        logic [31:0] secs;
        calendar_t   cal;
    } dated_t;

    typedef struct packed {
        logic        wait_drain;
        logic [31:0] secs;
    } epoch_req_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        epoch_valid   = 1'b0;
    logic        epoch_stall;
    logic [31:0] epoch_seconds = '0;
    logic        cal_valid;
    logic        cal_stall     = 1'b0;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    epoch_req_t epoch_queue[$];
    dated_t     calendar_due[$];
    int         stim_total   = 0;
    int         accepted_cnt = 0;
    int         cal_seen     = 0;
    int         error_cnt    = 0;
    int         cycle_count  = 0;
    int         holdoff_left = 0;
    logic       holdoff_done = 1'b0;
    logic       in_fire      = 1'b0;
    logic       calm;

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    epoch_seconds_to_calendar_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .epoch_valid   (epoch_valid),
        .epoch_stall   (epoch_stall),
        .epoch_seconds (epoch_seconds),
        .cal_valid     (cal_valid),
        .cal_stall     (cal_stall),
        .year          (year),
        .month         (month),
        .day_of_month  (day_of_month),
        .hour          (hour),
        .minute        (minute),
        .second        (second)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int leaps_through(input int y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    // Days from the epoch to January 1 of year y
    function automatic int year_start_day(input int y);
        return (y - BASE_YEAR) * 365 + leaps_through(y - 1) - leaps_through(BASE_YEAR - 1);
    endfunction

    // m counts from 0 for January
    function automatic int month_days(input int m, input bit leap);
        case (m)
            1:         return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:   return 31;
        endcase
    endfunction

    function automatic calendar_t to_calendar(input logic [31:0] secs);
        int unsigned tod;
        int          day_cnt;
        int          yr;
        int          mon;
        calendar_t   c;
        day_cnt  = int'(secs / DAY_SECS);
        tod      = secs % DAY_SECS;
        c.hour   = 5'(tod / HOUR_SECS);
        c.minute = 6'((tod % HOUR_SECS) / 60);
        c.second = 6'(tod % 60);
        // The days/365 estimate overshoots by at most one year
        yr = BASE_YEAR + day_cnt / 365;
        day_cnt -= year_start_day(yr);
        if (day_cnt < 0) begin
            yr = yr - 1;
            day_cnt += leap_year(yr) ? 366 : 365;
        end
        mon = 0;
        while (mon < 11 && day_cnt >= month_days(mon, leap_year(yr))) begin
            day_cnt -= month_days(mon, leap_year(yr));
            mon = mon + 1;
        end
        c.year  = 12'(yr);
        c.month = 4'(mon + 1);
        c.mday  = 5'(day_cnt + 1);
        return c;
    endfunction

    function automatic logic [31:0] clip_secs(input longint s);
        if (s < 0)
            return 32'd0;
        if (s > MAX_SECS)
            return 32'hFFFF_FFFF;
        return s[31:0];
    endfunction

    task automatic queue_request(input logic [31:0] secs, input logic wait_drain);
        epoch_req_t r;
        r.secs       = secs;
        r.wait_drain = wait_drain;
        epoch_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] secs,
                                   input int got, input int want);
        $display("%0t ERROR %s, epoch %0d: got %0d, want %0d", $time, what, secs, got, want);
        error_cnt++;
    endtask

    // Request driver: present the next request once the current one is taken
    always @(negedge clk) begin
        epoch_req_t nxt;
        if (rst_n && (!epoch_valid || in_fire)) begin
            if (epoch_queue.size() == 0
                || (epoch_queue[0].wait_drain && calendar_due.size() != 0)
                || (!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
                epoch_valid <= 1'b0;
            end
            else begin
                nxt = epoch_queue.pop_front();
                epoch_valid   <= 1'b1;
                epoch_seconds <= nxt.secs;
            end
        end
    end

    // Long hold-off on the result side so the block backs up into its input
    always @(negedge clk) begin
        if (rst_n) begin
            if (!holdoff_done && cal_seen >= HOLDOFF_AFTER) begin
                holdoff_left <= HOLDOFF_CYCLES;
                holdoff_done <= 1'b1;
            end
            else if (holdoff_left != 0) begin
                holdoff_left <= holdoff_left - 1;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n)
            cal_stall <= (holdoff_left != 0) || (!calm && $urandom_range(0, 99) < IDLE_PCT);
    end

    // Monitor: record accepted requests and check results against predictions
    always @(posedge clk) begin
        dated_t due;
        in_fire <= rst_n && epoch_valid && !epoch_stall;
        if (rst_n && epoch_valid && !epoch_stall) begin
            due.secs = epoch_seconds;
            due.cal  = to_calendar(epoch_seconds);
            calendar_due.push_back(due);
            accepted_cnt++;
        end
        if (rst_n && cal_valid && !cal_stall) begin
            cal_seen++;
            if (calendar_due.size() == 0) begin
                report_mismatch("result with no request pending, year", 32'd0,
                                int'(year), 0);
            end
            else begin
                due = calendar_due.pop_front();
                if (year !== due.cal.year)
                    report_mismatch("year", due.secs, int'(year), int'(due.cal.year));
                if (month !== due.cal.month)
                    report_mismatch("month", due.secs, int'(month), int'(due.cal.month));
                if (day_of_month !== due.cal.mday)
                    report_mismatch("day_of_month", due.secs,
                                    int'(day_of_month), int'(due.cal.mday));
                if (hour !== due.cal.hour)
                    report_mismatch("hour", due.secs, int'(hour), int'(due.cal.hour));
                if (minute !== due.cal.minute)
                    report_mismatch("minute", due.secs, int'(minute), int'(due.cal.minute));
                if (second !== due.cal.second)
                    report_mismatch("second", due.secs, int'(second), int'(due.cal.second));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int     pick;
        int     yr;
        longint base;
        // Range ends, the last second of the first day, the first second of the second day and the 2^31 turnover
        queue_request(32'd0, 1'b0);
        queue_request(32'hFFFF_FFFF, 1'b0);
        queue_request(32'd86399, 1'b0);
        queue_request(32'd86400, 1'b0);
        queue_request(32'h7FFF_FFFF, 1'b0);
        queue_request(32'h8000_0000, 1'b0);
        // Year turnovers, the end of leap year 1972 where the estimate overshoots, and 29 February 1972
        queue_request(32'd31535999, 1'b0);
        queue_request(32'd31536000, 1'b0);
        queue_request(32'd94608000, 1'b0);
        queue_request(32'd94694399, 1'b0);
        queue_request(32'd68169600, 1'b0);
        // 2000 is a leap century
        queue_request(32'd946684800, 1'b0);
        queue_request(32'd951782400, 1'b0);
        queue_request(32'd951868800, 1'b0);
        queue_request(32'd978307199, 1'b0);
        // 2100 is not
        queue_request(32'd4102444799, 1'b0);
        queue_request(32'd4107456000, 1'b0);
        queue_request(32'd4107542400, 1'b0);
        queue_request(32'd4291747199, 1'b0);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                base = longint'($urandom);
            end
            else if (pick < 75) begin
                // First or last second of a random day
                base = longint'($urandom_range(0, 49710)) * DAY_SECS;
                if ($urandom_range(0, 1) == 1)
                    base = base + DAY_SECS - 1;
            end
            else if (pick < 95) begin
                // Around New Year or the end of February
                yr   = $urandom_range(BASE_YEAR + 1, 2106);
                base = longint'(year_start_day(yr));
                if ($urandom_range(0, 1) == 1)
                    base = base + 59;
                base = base * DAY_SECS + $urandom_range(0, 2 * DAY_SECS - 1) - DAY_SECS;
            end
            else begin
                base = MAX_SECS - $urandom_range(0, 200000);
            end
            queue_request(clip_secs(base), (i == 0) || (i == RANDOM_REQS / 2));
        end
        stim_total = epoch_queue.size();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < stim_total || calendar_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
